### hdl/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared key, request, cell control and result types.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    typedef logic signed [31:0] t_key;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_CHANGE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_REPLACE,
        CELL_SORT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_key     key;
        t_key     new_key;
    } t_cell_ctl;

    typedef struct packed {
        t_key       min_value;
        logic       was_empty;
        logic       was_full;
        logic [7:0] entry_count;
    } t_result;

endpackage

### hdl/mhpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue cell
// Holds one key of the sorted chain; inserts, shifts, replaces and takes
// part in odd-even exchange passes with its neighbours.
// ----------------------------------------------------------------------------
module mhpq_cell
    import mhpq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  logic      i_left_ok,
    input  logic      i_right_valid,
    input  logic      i_sort_low,
    input  logic      i_left_gt,
    input  t_key      i_left,
    input  t_key      i_right,
    output t_key      o_value,
    output logic      o_gt,
    output logic      o_hit
);

    t_key r_value;
    t_key n_value;

    always_comb begin
        o_gt    = !i_valid || (i_ctl.key < r_value);
        o_hit   = i_valid && (r_value == i_ctl.key);
        n_value = r_value;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (i_left_gt) begin
                    n_value = i_left;
                end else if (o_gt) begin
                    n_value = i_ctl.key;
                end
            end
            CELL_SHIFT: begin
                n_value = i_right;
            end
            CELL_REPLACE: begin
                if (o_hit) begin
                    n_value = i_ctl.new_key;
                end
            end
            CELL_SORT: begin
                if (i_sort_low) begin
                    if (i_valid && i_right_valid && (i_right < r_value)) begin
                        n_value = i_right;
                    end
                end else begin
                    if (i_valid && i_left_ok && (r_value < i_left)) begin
                        n_value = i_left;
                    end
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### hdl/min_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue unit
// Keys are held in ascending order along a chain of cells; cell 0 is the
// minimum. Requests arrive on the input channel (i_in_valid/o_in_ready) and
// every request gives exactly one result beat on the output channel
// (o_out_valid/i_out_ready).
// Insert, extract and peek complete in the cycle of acceptance: the result
// beat is registered and a new request may follow at once while o_in_ready is high.
// Change key replaces matching cells, then, when something matched and more
// than one key is held, runs one odd-even exchange pass per held key across
// the chain.
// A result that the receiver does not take waits in the output register;
// one more result parks in a holding register, after which o_in_ready
// stays low until the receiver takes a beat.
// Reset empties the queue and drops any pending result; cell contents are
// not cleared, only the entry count.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  t_key        i_key,
    input  t_key        i_new_key,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_key        o_min_value,
    output logic        o_was_empty,
    output logic        o_was_full,
    output logic [7:0]  o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_SORT
    } t_state;

    t_state  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pass, n_pass;
    logic    r_out_valid;
    t_result r_out;
    logic    r_pnd_valid;
    t_result r_pnd;

    t_cell_ctl     w_ctl;
    t_key          w_value [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_hit;
    logic          w_accept;
    logic          w_any_hit;
    logic          w_full;
    logic          w_empty;
    logic          w_emit;
    t_result       w_res;
    logic [31:0]   w_cnt_wide;

    assign o_in_ready = (r_state == S_IDLE) && !r_pnd_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_any_hit  = |w_hit;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_empty    = (r_count == '0);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic w_left_gt;
            logic w_right_valid;
            logic w_sort_low;
            t_key w_left;
            t_key w_right;

            assign w_valid[g]  = (CW'(g) < r_count);
            assign w_sort_low  = (1'(g % 2) == r_pass[0]);

            if (g == 0) begin : g_first
                assign w_left_gt = 1'b0;
                assign w_left    = '0;
            end else begin : g_mid
                assign w_left_gt = w_gt[g-1];
                assign w_left    = w_value[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_right_valid = 1'b0;
                assign w_right       = '0;
            end else begin : g_inner
                assign w_right_valid = w_valid[g+1];
                assign w_right       = w_value[g+1];
            end

            mhpq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_valid       (w_valid[g]),
                .i_left_ok     (g != 0),
                .i_right_valid (w_right_valid),
                .i_sort_low    (w_sort_low),
                .i_left_gt     (w_left_gt),
                .i_left        (w_left),
                .i_right       (w_right),
                .o_value       (w_value[g]),
                .o_gt          (w_gt[g]),
                .o_hit         (w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        w_ctl.op      = CELL_HOLD;
        w_ctl.key     = i_key;
        w_ctl.new_key = i_new_key;
        n_state       = r_state;
        n_count       = r_count;
        n_pass        = r_pass;
        w_emit        = 1'b0;
        w_res.min_value = '0;
        w_res.was_empty = 1'b0;
        w_res.was_full  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_req'(i_req_type))
                        REQ_INSERT: begin
                            w_emit = 1'b1;
                            if (w_full) begin
                                w_res.was_full = 1'b1;
                            end else begin
                                w_ctl.op = CELL_INSERT;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        REQ_EXTRACT: begin
                            w_emit = 1'b1;
                            if (w_empty) begin
                                w_res.was_empty = 1'b1;
                            end else begin
                                w_ctl.op        = CELL_SHIFT;
                                w_res.min_value = w_value[0];
                                n_count         = r_count - CW'(1);
                            end
                        end
                        REQ_PEEK: begin
                            w_emit = 1'b1;
                            if (w_empty) begin
                                w_res.was_empty = 1'b1;
                            end else begin
                                w_res.min_value = w_value[0];
                            end
                        end
                        REQ_CHANGE: begin
                            w_ctl.op = CELL_REPLACE;
                            if (w_any_hit && (r_count > CW'(1))) begin
                                n_state = S_SORT;
                                n_pass  = '0;
                            end else begin
                                w_emit = 1'b1;
                            end
                        end
                        default: begin
                            w_emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SORT: begin
                w_ctl.op = CELL_SORT;
                n_pass   = r_pass + CW'(1);
                if (r_pass == r_count - CW'(1)) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_cnt_wide        = 32'(n_count);
        w_res.entry_count = w_cnt_wide[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
            r_pnd_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pass  <= n_pass;
            if (!r_out_valid || i_out_ready) begin
                if (r_pnd_valid) begin
                    r_out       <= r_pnd;
                    r_out_valid <= 1'b1;
                    r_pnd_valid <= 1'b0;
                end else if (w_emit) begin
                    r_out       <= w_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_emit) begin
                r_pnd       <= w_res;
                r_pnd_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_min_value   = r_out.min_value;
    assign o_was_empty   = r_out.was_empty;
    assign o_was_full    = r_out.was_full;
    assign o_entry_count = r_out.entry_count;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue unit testbench
// Drives insert, extract, peek and change-key requests through the
// valid/ready channels. A shadow copy of the stored keys predicts every
// result beat, and each beat is checked field by field in order. A short
// directed run covers the empty and extreme cases. Random bursts then grow
// the queue to full and drain it to empty again, under four idling and
// back-pressure phases.
// ----------------------------------------------------------------------------
module testbench
    import mhpq_pkg::*;
();

    localparam int   HEAP_DEPTH   = 128;
    localparam int   CLK_HALF     = 2;
    localparam int   RESET_CYCLES = 7;
    localparam int   PHASE_ITEMS  = 360;
    localparam int   REPORT_LIMIT = 100;
    localparam int   SETTLE_CYCLES = 200;
    localparam int   TIMEOUT_NS   = 8_000_000;
    localparam t_key MIN_KEY      = 32'sh8000_0000;
    localparam t_key MAX_KEY      = 32'sh7fff_ffff;
    localparam t_key EXTREME_KEYS [4] = '{MIN_KEY, MAX_KEY, 32'sh0, -32'sh1};

    typedef enum int {
        MIX_CHURN,
        MIX_GROW,
        MIX_FILL,
        MIX_SHRINK
    } t_mix;

    class heap_scoreboard;
        t_key    held[$];
        t_result awaited[$];
        int      errors = 0;

        function int lowest_slot();
            int slot = 0;
            foreach (held[i]) if (held[i] < held[slot]) slot = i;
            return slot;
        endfunction

        function void note_request(t_req req, t_key key_in, t_key new_in);
            t_result want;
            int      slot;
            want = '0;
            case (req)
                REQ_INSERT: begin
                    if (held.size() >= HEAP_DEPTH) want.was_full = 1'b1;
                    else held.push_back(key_in);
                end
                REQ_EXTRACT, REQ_PEEK: begin
                    if (held.size() == 0) begin
                        want.was_empty = 1'b1;
                    end else begin
                        slot = lowest_slot();
                        want.min_value = held[slot];
                        if (req == REQ_EXTRACT) held.delete(slot);
                    end
                end
                default: begin
                    foreach (held[i]) if (held[i] == key_in) held[i] = new_in;
                end
            endcase
            want.entry_count = 8'(held.size());
            awaited.push_back(want);
        endfunction

        function void check_field(string field, logic signed [32:0] want,
                                  logic signed [32:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result beat with nothing awaited, expected none, actual %0d",
                             $time, got.min_value);
                return;
            end
            want = awaited.pop_front();
            check_field("min_value", want.min_value, got.min_value);
            check_field("was_empty", want.was_empty, got.was_empty);
            check_field("was_full", want.was_full, got.was_full);
            check_field("entry_count", want.entry_count, got.entry_count);
        endfunction
    endclass

    logic           i_clk         = 1'b0;
    logic           i_rst_n       = 1'b0;
    logic           i_in_valid    = 1'b0;
    logic           o_in_ready;
    logic [1:0]     i_req_type    = REQ_INSERT;
    t_key           i_key         = '0;
    t_key           i_new_key     = '0;
    logic           o_out_valid;
    logic           i_out_ready   = 1'b0;
    t_key           o_min_value;
    logic           o_was_empty;
    logic           o_was_full;
    logic [7:0]     o_entry_count;
    int             idle_pct      = 0;
    int             stall_pct     = 0;
    heap_scoreboard shadow_heap   = new();

    min_heap_priority_queue_unit #(
        .CAPACITY(HEAP_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .i_new_key    (i_new_key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_min_value  (o_min_value),
        .o_was_empty  (o_was_empty),
        .o_was_full   (o_was_full),
        .o_entry_count(o_entry_count)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            shadow_heap.check_result({o_min_value, o_was_empty, o_was_full, o_entry_count});
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #TIMEOUT_NS;
        $display("min_heap_priority_queue_unit regression: fail");
        $finish;
    end

    function automatic t_key rand_key();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return t_key'($urandom_range(15)) - 8;
            5:             return EXTREME_KEYS[$urandom_range(3)];
            default:       return t_key'($urandom);
        endcase
    endfunction

    task automatic send_request(t_req req, t_key key_in, t_key new_in);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key      <= key_in;
        i_new_key  <= new_in;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        shadow_heap.note_request(req, key_in, new_in);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (shadow_heap.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(t_mix mix);
        int   roll;
        int   ins_w;
        int   ext_w;
        int   peek_w;
        t_req req;
        t_key key_in;
        t_key new_in;
        case (mix)
            MIX_GROW: begin
                ins_w = 60; ext_w = 10; peek_w = 5;
            end
            MIX_FILL: begin
                ins_w = 85; ext_w = 5; peek_w = 5;
            end
            MIX_SHRINK: begin
                ins_w = 5; ext_w = 85; peek_w = 5;
            end
            default: begin
                ins_w = 35; ext_w = 25; peek_w = 10;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_w) req = REQ_INSERT;
        else if (roll < ins_w + ext_w) req = REQ_EXTRACT;
        else if (roll < ins_w + ext_w + peek_w) req = REQ_PEEK;
        else req = REQ_CHANGE;
        key_in = rand_key();
        new_in = rand_key();
        if (req == REQ_CHANGE && shadow_heap.held.size() != 0 && $urandom_range(9) < 6)
            key_in = shadow_heap.held[$urandom_range(shadow_heap.held.size() - 1)];
        if (req == REQ_CHANGE && $urandom_range(9) == 0) new_in = key_in;
        send_request(req, key_in, new_in);
    endtask

    task automatic run_phase(int idle, int stall);
        int   sent;
        int   burst;
        t_mix mix;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        mix       = MIX_CHURN;
        while (sent < PHASE_ITEMS) begin
            burst = 0;
            case (mix)
                MIX_FILL: begin
                    while (shadow_heap.held.size() < HEAP_DEPTH) begin
                        send_random(MIX_FILL);
                        burst++;
                    end
                    repeat (8) send_request(REQ_INSERT, rand_key(), rand_key());
                    burst += 8;
                end
                MIX_SHRINK: begin
                    while (shadow_heap.held.size() != 0) begin
                        send_random(MIX_SHRINK);
                        burst++;
                    end
                    repeat (4) send_random(MIX_SHRINK);
                    burst += 4;
                end
                default: begin
                    burst = $urandom_range(20, 60);
                    repeat (burst) send_random(mix);
                end
            endcase
            sent += burst;
            mix = t_mix'((mix + 1) % 4);
        end
        drain_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(REQ_PEEK, 32'sh0, 32'sh0);
        send_request(REQ_EXTRACT, -32'sh1, 32'sh0);
        send_request(REQ_CHANGE, 32'sh0, 32'sh5);
        send_request(REQ_INSERT, MAX_KEY, 32'sh0);
        send_request(REQ_INSERT, MIN_KEY, -32'sh1);
        send_request(REQ_INSERT, 32'sh0, MAX_KEY);
        send_request(REQ_INSERT, -32'sh1, MIN_KEY);
        send_request(REQ_INSERT, 32'sh7, 32'sh0);
        send_request(REQ_INSERT, 32'sh7, 32'sh0);
        send_request(REQ_PEEK, MAX_KEY, MAX_KEY);
        send_request(REQ_CHANGE, 32'sh7, 32'sh7);
        send_request(REQ_CHANGE, 32'sh3039, 32'sh1);
        send_request(REQ_CHANGE, 32'sh7, -32'sh5);
        send_request(REQ_CHANGE, -32'sh1, MAX_KEY);
        send_request(REQ_CHANGE, MIN_KEY, 32'sh2);
        repeat (6) send_request(REQ_EXTRACT, 32'sh0, 32'sh0);
        send_request(REQ_EXTRACT, MIN_KEY, MAX_KEY);
        send_request(REQ_PEEK, MAX_KEY, MIN_KEY);
        drain_results();

        run_phase(0, 0);
        run_phase(80, 0);
        run_phase(0, 80);
        run_phase(31, 31);

        idle_pct  = 0;
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (shadow_heap.errors == 0 && shadow_heap.awaited.size() == 0)
            $display("min_heap_priority_queue_unit regression: pass");
        else
            $display("min_heap_priority_queue_unit regression: fail");
        $finish;
    end

endmodule
